/* rtl/a64dp_pkg.sv */
// ----------------------------------------------------------------------------
// a64dp_pkg
// Types, codes and mask expansion helpers for the A64 immediate decoder.
// ----------------------------------------------------------------------------
package a64dp_pkg;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_UNALLOC = 2'd1,
		ST_UNSUPP  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		GRP_ADR      = 4'd0,
		GRP_ADRP     = 4'd1,
		GRP_ADDSUB   = 4'd2,
		GRP_MINMAX   = 4'd3,
		GRP_LOGICAL  = 4'd4,
		GRP_BITFIELD = 4'd5,
		GRP_EXTRACT  = 4'd6,
		GRP_MOVEWIDE = 4'd7,
		GRP_UNKNOWN  = 4'd8
	} group_t;

	localparam logic [4:0] OP_NONE = 5'd0;
	localparam logic [4:0] OP_ADD  = 5'd1;
	localparam logic [4:0] OP_SUB  = 5'd2;
	localparam logic [4:0] OP_SMAX = 5'd3;
	localparam logic [4:0] OP_AND  = 5'd7;
	localparam logic [4:0] OP_SBFM = 5'd11;
	localparam logic [4:0] OP_EXTR = 5'd14;
	localparam logic [4:0] OP_MOVN = 5'd15;
	localparam logic [4:0] OP_MOVZ = 5'd16;
	localparam logic [4:0] OP_MOVK = 5'd17;

	localparam logic [31:0] PCREL_MASK = 32'h1F000000;
	localparam logic [31:0] PCREL_VAL  = 32'h10000000;
	localparam logic [31:0] ADDSUB_MASK = 32'h1F800000;
	localparam logic [31:0] ADDSUB_VAL  = 32'h11000000;
	localparam logic [31:0] MINMAX_MASK = 32'h7FF00000;
	localparam logic [31:0] MINMAX_VAL  = 32'h11C00000;
	localparam logic [31:0] LOGIC_VAL   = 32'h12000000;
	localparam logic [31:0] BITF_VAL    = 32'h13000000;
	localparam logic [31:0] EXTR_MASK   = 32'h7FA00000;
	localparam logic [31:0] EXTR_VAL    = 32'h13800000;
	localparam logic [31:0] MOVW_VAL    = 32'h12800000;

	// classified item passed from front to back
	typedef struct packed {
		status_t     status;
		group_t      grp;
		logic [4:0]  op;
		logic [4:0]  rd;
		logic [4:0]  rn;
		logic [4:0]  rm;
		logic [4:0]  ra;
		logic [3:0]  flags;
		logic [63:0] imm;
		logic [5:0]  sh;
		logic [5:0]  rot;
		logic        need_mask;
		logic        logical;
		logic        w64;
		logic        nbit;
		logic [5:0]  imms;
	} front_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  grp;
		logic [4:0]  op;
		logic [4:0]  rd;
		logic [4:0]  rn;
		logic [4:0]  rm;
		logic [4:0]  ra;
		logic [3:0]  flags;
		logic [63:0] val;
		logic [63:0] tm;
		logic [5:0]  sh;
		logic [5:0]  rot;
	} result_t;

	function automatic logic [63:0] ones64(input logic [6:0] n);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 64; i++) begin
			m[i] = (7'(i) < n);
		end
		return m;
	endfunction

	// rotate right within an element of size e (e power of two, 2..64)
	function automatic logic [63:0] ror_elem(input logic [63:0] v, input logic [5:0] r,
			input logic [6:0] e);
		logic [127:0] dbl;
		logic [63:0]  m;
		logic [63:0]  res;
		m = ones64(e);
		dbl = {64'd0, v & m};
		dbl = dbl | (dbl << e);
		res = 64'(dbl >> r) & m;
		return res;
	endfunction

	function automatic logic [63:0] repl(input logic [63:0] v, input logic [6:0] e);
		logic [63:0] acc;
		acc = '0;
		for (int i = 0; i < 64; i++) begin
			acc[i] = v[i & (int'(e) - 1)];
		end
		return acc;
	endfunction

endpackage

/* rtl/a64dp_front.sv */
// ----------------------------------------------------------------------------
// a64dp_front
// Matches the instruction class and extracts fields and plain immediates.
// ----------------------------------------------------------------------------
module a64dp_front import a64dp_pkg::*; (
	input  logic [31:0]  w,
	output front_item_t  item
);

	logic        sf;
	logic [1:0]  opc;
	logic        nbit;
	logic [5:0]  immr;
	logic [5:0]  imms;
	logic [20:0] imm21;
	logic [5:0]  hwsh;

	assign sf    = w[31];
	assign opc   = w[30:29];
	assign nbit  = w[22];
	assign immr  = w[21:16];
	assign imms  = w[15:10];
	assign imm21 = {w[23:5], w[30:29]};
	assign hwsh  = {w[22:21], 4'd0};

	always_comb begin
		item = '0;
		item.status = ST_UNSUPP;
		item.grp    = GRP_UNKNOWN;
		item.rd     = w[4:0];
		item.rn     = w[9:5];
		item.rm     = w[20:16];
		item.ra     = w[14:10];
		item.flags  = {3'd0, sf};
		item.w64    = sf;
		item.nbit   = nbit;
		item.imms   = imms;
		priority if ((w & PCREL_MASK) == PCREL_VAL) begin
			item.rn = '0; item.rm = '0; item.ra = '0;
			item.flags = 4'd1;
			item.status = ST_OK;
			if (sf) begin
				item.grp = GRP_ADRP;
				item.imm = {{31{imm21[20]}}, imm21, 12'd0};
			end else begin
				item.grp = GRP_ADR;
				item.imm = {{43{imm21[20]}}, imm21};
			end
		end else if ((w & ADDSUB_MASK) == ADDSUB_VAL) begin
			item.grp = GRP_ADDSUB; item.status = ST_OK;
			item.op = w[30] ? OP_SUB : OP_ADD;
			item.sh = w[22] ? 6'd12 : 6'd0;
			item.imm = w[22] ? {40'd0, w[21:10], 12'd0} : {52'd0, w[21:10]};
			item.flags[1] = w[29];
			item.flags[2] = w[30];
		end else if ((w & MINMAX_MASK) == MINMAX_VAL) begin
			item.grp = GRP_MINMAX; item.status = ST_OK;
			item.imm = {56'd0, w[17:10]};
			item.op = OP_SMAX + {3'd0, w[19:18]};
		end else if ((w & ADDSUB_MASK) == LOGIC_VAL) begin
			item.grp = GRP_LOGICAL;
			item.op = OP_AND + {3'd0, opc};
			item.rot = immr;
			item.flags[3] = nbit;
			item.flags[1] = (opc == 2'd3);
			item.need_mask = 1'b1;
			item.logical = 1'b1;
			item.status = ST_OK;
		end else if ((w & ADDSUB_MASK) == BITF_VAL) begin
			item.grp = GRP_BITFIELD;
			item.op = OP_SBFM + {3'd0, opc};
			item.rot = immr;
			item.flags[3] = nbit;
			if (opc == 2'd3 || nbit != sf || (!sf && (immr[5] | imms[5]))) begin
				item.status = ST_UNALLOC;
			end else begin
				item.status = ST_OK;
				item.need_mask = 1'b1;
			end
		end else if ((w & EXTR_MASK) == EXTR_VAL) begin
			item.grp = GRP_EXTRACT;
			item.op = OP_EXTR;
			item.sh = imms;
			item.flags[3] = nbit;
			item.status = (nbit != sf || (!sf && imms[5])) ? ST_UNALLOC : ST_OK;
		end else if ((w & ADDSUB_MASK) == MOVW_VAL) begin
			item.grp = GRP_MOVEWIDE;
			item.op = (opc == 2'd0) ? OP_MOVN : (opc == 2'd2) ? OP_MOVZ : OP_MOVK;
			item.imm = {48'd0, w[20:5]};
			item.sh = hwsh;
			item.status = (opc == 2'd1 || (!sf && hwsh[5])) ? ST_UNALLOC : ST_OK;
		end else begin
			item.status = ST_UNSUPP;
		end
	end

endmodule

/* rtl/a64dp_back.sv */
// ----------------------------------------------------------------------------
// a64dp_back
// Expands logical and bitfield masks and clears fields of rejected items.
// ----------------------------------------------------------------------------
module a64dp_back import a64dp_pkg::*; (
	input  front_item_t item,
	output result_t     res
);

	logic [6:0]  v;
	logic [2:0]  len;
	logic        bad;
	logic [5:0]  levels;
	logic [5:0]  s;
	logic [5:0]  r;
	logic [5:0]  d;
	logic [6:0]  e;
	logic [63:0] wm;
	logic [63:0] tm;
	status_t     st;

	always_comb begin
		v = {item.nbit, ~item.imms};
		len = 3'd0;
		for (int k = 0; k < 7; k++) begin
			if (v[k]) len = 3'(k);
		end
		levels = 6'((7'd1 << len) - 7'd1);
		s = item.imms & levels;
		r = item.rot & levels;
		d = (s - r) & levels;
		e = 7'd1 << len;
		bad = (v == 7'd0) || (len == 3'd0) || (!item.w64 && len == 3'd6)
			|| (item.logical && s == levels);
		wm = repl(ror_elem(ones64(7'(s) + 7'd1), r, e), e);
		tm = repl(ones64(7'(d) + 7'd1), e);
		if (!item.w64) begin
			wm[63:32] = '0;
			tm[63:32] = '0;
		end
		st = item.status;
		if (item.need_mask && bad) st = ST_UNALLOC;

		res.status = st;
		res.grp    = item.grp;
		res.op     = item.op;
		res.rd     = item.rd;
		res.rn     = item.rn;
		res.rm     = item.rm;
		res.ra     = item.ra;
		res.flags  = item.flags;
		res.val    = item.need_mask ? wm : item.imm;
		res.tm     = item.need_mask ? tm : 64'd0;
		res.sh     = item.sh;
		res.rot    = item.rot;
		if (st != ST_OK) begin
			res = '0;
			res.status = st;
			res.grp = item.grp;
		end
	end

endmodule

/* rtl/a64_dp_immediate_decoder_core.sv */
// ----------------------------------------------------------------------------
// a64_dp_immediate_decoder_core
// A64 data-processing-immediate decoder with a two-entry queue between
// the classify stage and the mask expansion stage.
// ----------------------------------------------------------------------------
// path: an accepted word is classified into the queue, then its result is registered in the output stage
// throughput: one item per cycle while m_axis_tready holds; the front and back stages are combinational
// the two-entry queue lets front and back stall independently
// reset: arst_n clears queue and output valid flags; no payload reset
module a64_dp_immediate_decoder_core import a64dp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [31:0]  s_axis_tdata,   // [31:0] insn_word
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [1:0] status, [5:2] insn_group, [10:6] operation, [15:11] dest_reg,
	// [20:16] first_src_reg, [25:21] second_src_reg, [30:26] third_src_reg,
	// [34:31] flag_bits, [98:35] value_word, [162:99] top_mask,
	// [168:163] shift_count, [174:169] rotate_field, [175] zero
	output logic [175:0] m_axis_tdata
);

	front_item_t fitem;
	front_item_t q_mem_q [2];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	result_t     bres;
	result_t     out_s2;
	logic        out_vld_q;
	logic        push, pop, out_free;

	a64dp_front u_front (.w(s_axis_tdata), .item(fitem));
	a64dp_back  u_back  (.item(q_mem_q[rp_q]), .res(bres));

	assign s_axis_tready = (cnt_q != 2'd2);
	assign push = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_vld_q || m_axis_tready;
	assign pop = (cnt_q != 2'd0) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
			out_vld_q <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
			if (out_free) out_vld_q <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wp_q] <= fitem;
		if (pop) out_s2 <= bres;
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = {1'b0, out_s2.rot, out_s2.sh, out_s2.tm, out_s2.val,
		out_s2.flags, out_s2.ra, out_s2.rm, out_s2.rn, out_s2.rd, out_s2.op,
		out_s2.grp, out_s2.status};

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count overflow");
	a_full_noready: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !s_axis_tready) else $error("ready while queue full");
	a_pop_out: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> m_axis_tvalid) else $error("popped item not presented");

endmodule
